>>> rtl/core/stc_pkg.sv
// Shared types and constants for the signed triad counter.
package stc_pkg;

  localparam int DEF_MAX_NODES = 256;

  localparam int CFG_W     = 9;
  localparam int IDX_IN_W  = 8;
  localparam int CELL_W    = 16;
  localparam int PAIR_W    = 16;
  localparam int PAIR_CW   = PAIR_W + 1;
  localparam int TRIAD_W   = 22;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 9'd256;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_COUNT = 1'b1;

  // stored sign codes
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  typedef enum logic [1:0] {
    RK_PAIR,
    RK_SIJ,
    RK_TRI
  } rd_kind_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_PAIR,
    W_SIJ,
    W_TRI,
    W_FIN
  } walk_state_t;

  // read request issued by the walker, one per cycle
  typedef struct packed {
    logic     valid;
    rd_kind_t kind;
    logic     fin;
  } stc_req_t;

endpackage

>>> rtl/core/stc_walker.sv
// Address sequencer: sweeps the pair cells, then every i<j<k triple.
module stc_walker #(
  parameter int MAX_NODES = stc_pkg::DEF_MAX_NODES,
  parameter int IDXW      = $clog2(MAX_NODES),
  parameter int NW        = $clog2(MAX_NODES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NW-1:0]        n,
  output logic                 busy,
  output stc_pkg::stc_req_t    req,
  output logic [IDXW-1:0]      a_row,
  output logic [IDXW-1:0]      a_col,
  output logic [IDXW-1:0]      b_row,
  output logic [IDXW-1:0]      b_col
);

  stc_pkg::walk_state_t state_r, state_nxt;
  logic [IDXW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [NW-1:0]   i_w, j_w, k_w;

  assign i_w  = NW'(i_r);
  assign j_w  = NW'(j_r);
  assign k_w  = NW'(k_r);
  assign busy = (state_r != stc_pkg::W_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stc_pkg::W_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    n_r <= n_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    req       = '0;
    a_row     = i_r;
    a_col     = j_r;
    b_row     = k_r;
    b_col     = i_r;
    unique case (state_r)
      stc_pkg::W_IDLE: begin
        if (start) begin
          n_nxt     = n;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = (n == '0) ? stc_pkg::W_FIN : stc_pkg::W_PAIR;
        end
      end
      stc_pkg::W_PAIR: begin
        req.valid = 1'b1;
        req.kind  = stc_pkg::RK_PAIR;
        if (j_w == n_r - NW'(1)) begin
          j_nxt = '0;
          if (i_w == n_r - NW'(1)) begin
            i_nxt     = '0;
            j_nxt     = IDXW'(1);
            state_nxt = (n_r >= NW'(3)) ? stc_pkg::W_SIJ : stc_pkg::W_FIN;
          end else begin
            i_nxt = i_r + IDXW'(1);
          end
        end else begin
          j_nxt = j_r + IDXW'(1);
        end
      end
      stc_pkg::W_SIJ: begin
        req.valid = 1'b1;
        req.kind  = stc_pkg::RK_SIJ;
        k_nxt     = j_r + IDXW'(1);
        state_nxt = stc_pkg::W_TRI;
      end
      stc_pkg::W_TRI: begin
        req.valid = 1'b1;
        req.kind  = stc_pkg::RK_TRI;
        a_row     = j_r;
        a_col     = k_r;
        b_row     = k_r;
        b_col     = i_r;
        if (k_w == n_r - NW'(1)) begin
          if (j_w == n_r - NW'(2)) begin
            if (i_w == n_r - NW'(3)) begin
              state_nxt = stc_pkg::W_FIN;
            end else begin
              i_nxt     = i_r + IDXW'(1);
              j_nxt     = i_r + IDXW'(2);
              state_nxt = stc_pkg::W_SIJ;
            end
          end else begin
            j_nxt     = j_r + IDXW'(1);
            state_nxt = stc_pkg::W_SIJ;
          end
        end else begin
          k_nxt = k_r + IDXW'(1);
        end
      end
      stc_pkg::W_FIN: begin
        req.fin   = 1'b1;
        state_nxt = stc_pkg::W_IDLE;
      end
      default: begin
        state_nxt = stc_pkg::W_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/signed_triad_counter.sv
// Top level: sign store, count accumulators and channel handshakes.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_stall, command,row,col,value | request in
//  out     | out_valid/out_stall, seven counts       | result out
//  cfg     | cfg_valid/cfg_ready, cfg_node_count     | register write
//
// A write request gives no result. A count request has the walker read one cell
// (or one cell pair on the two store copies) per cycle: all n*n pair cells, one
// cell per i<j with j < n-1 and one cell pair per i<j<k triple, n the effective
// node count; that sequence sets the length of the count.
// in_stall stays high from an accepted count until its result is loaded into
// the output register; writes are taken while a result waits on out_stall.
// Reset sets node_count to 256; the sign store holds no reset value.
module signed_triad_counter #(
  parameter int MAX_NODES = stc_pkg::DEF_MAX_NODES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [stc_pkg::IDX_IN_W-1:0]      in_row,
  input  logic [stc_pkg::IDX_IN_W-1:0]      in_col,
  input  logic signed [stc_pkg::CELL_W-1:0] in_cell_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stc_pkg::PAIR_W-1:0]        out_neg_pairs,
  output logic [stc_pkg::PAIR_W-1:0]        out_pos_pairs,
  output logic [stc_pkg::TRIAD_W-1:0]       out_closed_triads,
  output logic [stc_pkg::TRIAD_W-1:0]       out_two_pos_one_neg,
  output logic [stc_pkg::TRIAD_W-1:0]       out_all_negative,
  output logic [stc_pkg::TRIAD_W-1:0]       out_all_positive,
  output logic [stc_pkg::TRIAD_W-1:0]       out_one_pos_two_neg,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stc_pkg::CFG_W-1:0]         cfg_node_count
);

  localparam int IDXW  = $clog2(MAX_NODES);
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int AW    = 2 * IDXW;
  localparam int DEPTH = 1 << AW;
  localparam int WIDE  = ((IDXW > stc_pkg::IDX_IN_W) ? IDXW : stc_pkg::IDX_IN_W) + 1;
  localparam int CMPW  = (NW > stc_pkg::CFG_W) ? NW : stc_pkg::CFG_W;
  localparam int PW    = stc_pkg::PAIR_CW;
  localparam int TW    = stc_pkg::TRIAD_W;

  // two copies of the store give two reads per cycle
  logic [1:0] mem_a [DEPTH];
  logic [1:0] mem_b [DEPTH];

  logic [stc_pkg::CFG_W-1:0] node_count_r;
  logic [1:0] rd_a_r, rd_b_r, sij_r;
  stc_pkg::stc_req_t req, req_d_r;
  logic pend_r;

  logic [PW-1:0] pos_cnt_r, neg_cnt_r;
  logic [TW-1:0] tot_r, cnt_a_r, cnt_b_r, cnt_c_r, cnt_d_r;

  logic out_valid_r;
  logic [stc_pkg::PAIR_W-1:0] neg_pairs_r, pos_pairs_r;
  logic [TW-1:0] closed_r, two_pos_r, all_neg_r, all_pos_r, one_pos_r;

  logic walk_busy, in_acc, count_go, wr_en, out_load;
  logic [IDXW-1:0] a_row, a_col, b_row, b_col;
  logic [WIDE-1:0] row_w, col_w;
  logic [CMPW-1:0] nc_w;
  logic [NW-1:0]   n_eff;
  logic [AW-1:0]   wr_addr;
  logic [1:0]      wr_code;
  logic            tri_hit;
  logic [1:0]      pos_num;

  assign cfg_ready = 1'b1;
  assign in_stall  = walk_busy | req_d_r.fin | pend_r;
  assign in_acc    = in_valid & ~in_stall;
  assign count_go  = in_acc & (in_command == stc_pkg::CMD_COUNT);

  assign nc_w  = CMPW'(node_count_r);
  assign n_eff = (nc_w > CMPW'(MAX_NODES)) ? NW'(MAX_NODES) : nc_w[NW-1:0];

  assign row_w   = WIDE'(in_row);
  assign col_w   = WIDE'(in_col);
  assign wr_en   = in_acc && (in_command == stc_pkg::CMD_WRITE) &&
                   (row_w < WIDE'(MAX_NODES)) && (col_w < WIDE'(MAX_NODES));
  assign wr_addr = {row_w[IDXW-1:0], col_w[IDXW-1:0]};
  assign wr_code = (in_cell_value == '0) ? stc_pkg::SIGN_ZERO :
                   in_cell_value[stc_pkg::CELL_W-1] ? stc_pkg::SIGN_NEG : stc_pkg::SIGN_POS;

  stc_walker #(
    .MAX_NODES (MAX_NODES),
    .IDXW      (IDXW),
    .NW        (NW)
  ) u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (count_go),
    .n     (n_eff),
    .busy  (walk_busy),
    .req   (req),
    .a_row (a_row),
    .a_col (a_col),
    .b_row (b_row),
    .b_col (b_col)
  );

  // writes only happen while the walker is idle, so no read can overlap them
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_code;
      mem_b[wr_addr] <= wr_code;
    end
    if (req.valid) begin
      rd_a_r <= mem_a[{a_row, a_col}];
      rd_b_r <= mem_b[{b_row, b_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= stc_pkg::NODE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_node_count;
    end
  end

  assign tri_hit = (sij_r == stc_pkg::SIGN_POS || sij_r == stc_pkg::SIGN_NEG) &&
                   (rd_a_r == stc_pkg::SIGN_POS || rd_a_r == stc_pkg::SIGN_NEG) &&
                   (rd_b_r == stc_pkg::SIGN_POS || rd_b_r == stc_pkg::SIGN_NEG);
  assign pos_num = 2'(sij_r == stc_pkg::SIGN_POS) + 2'(rd_a_r == stc_pkg::SIGN_POS) +
                   2'(rd_b_r == stc_pkg::SIGN_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_d_r <= '0;
    end else begin
      req_d_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (count_go) begin
      pos_cnt_r <= '0;
      neg_cnt_r <= '0;
      tot_r     <= '0;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      cnt_c_r   <= '0;
      cnt_d_r   <= '0;
    end else if (req_d_r.valid) begin
      case (req_d_r.kind)
        stc_pkg::RK_PAIR: begin
          if (rd_a_r == stc_pkg::SIGN_POS) pos_cnt_r <= pos_cnt_r + PW'(1);
          if (rd_a_r == stc_pkg::SIGN_NEG) neg_cnt_r <= neg_cnt_r + PW'(1);
        end
        stc_pkg::RK_SIJ: begin
          sij_r <= rd_a_r;
        end
        stc_pkg::RK_TRI: begin
          if (tri_hit) begin
            tot_r <= tot_r + TW'(1);
            // positive count 0..3 maps to sign sums -3, -1, +1, +3
            case (pos_num)
              2'd0:    cnt_b_r <= cnt_b_r + TW'(1);
              2'd1:    cnt_d_r <= cnt_d_r + TW'(1);
              2'd2:    cnt_a_r <= cnt_a_r + TW'(1);
              default: cnt_c_r <= cnt_c_r + TW'(1);
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign out_load = pend_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (req_d_r.fin) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      neg_pairs_r <= neg_cnt_r[PW-1:1];
      pos_pairs_r <= pos_cnt_r[PW-1:1];
      closed_r    <= tot_r;
      two_pos_r   <= cnt_a_r;
      all_neg_r   <= cnt_b_r;
      all_pos_r   <= cnt_c_r;
      one_pos_r   <= cnt_d_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_neg_pairs       = neg_pairs_r;
  assign out_pos_pairs       = pos_pairs_r;
  assign out_closed_triads   = closed_r;
  assign out_two_pos_one_neg = two_pos_r;
  assign out_all_negative    = all_neg_r;
  assign out_all_positive    = all_pos_r;
  assign out_one_pos_two_neg = one_pos_r;

endmodule

>>> rtl/core/stc_checker.sv
// Port-level assertions for the signed triad counter, bound to the top level.
module stc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_command,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [stc_pkg::TRIAD_W-1:0]       out_closed_triads,
  input logic [stc_pkg::TRIAD_W-1:0]       out_two_pos_one_neg,
  input logic [stc_pkg::TRIAD_W-1:0]       out_all_negative,
  input logic [stc_pkg::TRIAD_W-1:0]       out_all_positive,
  input logic [stc_pkg::TRIAD_W-1:0]       out_one_pos_two_neg
);

  localparam int TRIAD_SUM_W = stc_pkg::TRIAD_W;

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // every closed triad lands in exactly one class
  a_class_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_closed_triads == TRIAD_SUM_W'(out_two_pos_one_neg + out_all_negative +
                                       out_all_positive + out_one_pos_two_neg))
    else $error("triad classes do not add up");

  // an accepted count request raises in_stall to block further requests
  a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == stc_pkg::CMD_COUNT) |=> in_stall)
    else $error("request taken during a count");

  // a cell write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == stc_pkg::CMD_WRITE) && !out_valid |=> !out_valid)
    else $error("result after a write");

endmodule

bind signed_triad_counter stc_checker u_stc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_command          (in_command),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_closed_triads   (out_closed_triads),
  .out_two_pos_one_neg (out_two_pos_one_neg),
  .out_all_negative    (out_all_negative),
  .out_all_positive    (out_all_positive),
  .out_one_pos_two_neg (out_one_pos_two_neg)
);
